// ===== rtl/btc_pkg.sv =====
package btc_pkg;

    // Block geometry and pixel packing.
    localparam int ROWS      = 4;
    localparam int COLS      = 4;
    localparam int PIX_W     = 8;
    localparam int ROW_W     = COLS * PIX_W;

    // Sum widths for the mean.
    localparam int SUM_ROW_W = PIX_W + 2;
    localparam int SUM_W     = SUM_ROW_W + 2;
    localparam int MEAN_W    = 8;
    localparam int MEAN_SHIFT = 4;

    // Squared difference widths for the deviation.
    localparam int SQ_W      = 2 * PIX_W;
    localparam int SQ_ROW_W  = SQ_W + 2;
    localparam int SQ_SUM_W  = SQ_ROW_W + 2;
    localparam int VAR_W     = SQ_SUM_W - MEAN_SHIFT;

    // Square root pipeline.
    localparam int ROOT_W          = VAR_W / 2;
    localparam int REM_W           = ROOT_W + 3;
    localparam int DEV_W           = 7;
    localparam int MAP_W           = ROWS * COLS;
    localparam int STEPS_PER_STAGE = 2;
    localparam int SQRT_STAGES     = ROOT_W / STEPS_PER_STAGE;

    // Results that ride alongside the square root pipeline.
    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic [MAP_W-1:0]  bitmap;
    } btc_side_t;

    // Partial remainder and root of the digit-by-digit square root.
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_state_t;

    // One radix-4 step of the restoring square root: bring in two bits,
    // try to subtract 4*root+1, and shift one root bit in.
    function automatic sqrt_state_t sqrt_step(sqrt_state_t s, logic [1:0] pair);
        logic [REM_W-1:0] cur;
        logic [REM_W-1:0] trial;
        sqrt_state_t      res;
        cur   = {s.rem[REM_W-3:0], pair};
        trial = {1'b0, s.root, 2'b01};
        if (cur >= trial) begin
            res.rem  = cur - trial;
            res.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else begin
            res.rem  = cur;
            res.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

// ===== rtl/btc_sum_lane.sv =====
module btc_sum_lane
    import btc_pkg::*;
(
    input  logic                 clk,
    input  logic [ROW_W-1:0]     row,
    output logic [SUM_ROW_W-1:0] row_sum
);

    logic [SUM_ROW_W-1:0] row_sum_reg;
    logic [SUM_ROW_W-1:0] row_sum_next;

    // Add the four pixels of one row.
    always_comb
    begin
        row_sum_next = '0;
        for (int c = 0; c < COLS; c++)
        begin
            row_sum_next = row_sum_next + SUM_ROW_W'(row[c*PIX_W +: PIX_W]);
        end
    end

    always_ff @(posedge clk)
    begin
        row_sum_reg <= row_sum_next;
    end

    assign row_sum = row_sum_reg;

endmodule

// ===== rtl/btc_dev_lane.sv =====
module btc_dev_lane
    import btc_pkg::*;
(
    input  logic                clk,
    input  logic [ROW_W-1:0]    row,
    input  logic [MEAN_W-1:0]   mean,
    output logic [SQ_ROW_W-1:0] sq_sum,
    output logic [COLS-1:0]     nibble
);

    logic [SQ_W-1:0]     sq_reg [COLS];
    logic [SQ_W-1:0]     sq_next [COLS];
    logic [COLS-1:0]     above_reg;
    logic [COLS-1:0]     above_next;
    logic [SQ_ROW_W-1:0] sq_sum_reg;
    logic [SQ_ROW_W-1:0] sq_sum_next;
    logic [COLS-1:0]     nibble_reg;

    // Absolute difference from the mean, its square, and the level bit.
    always_comb
    begin
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] diff;
        for (int c = 0; c < COLS; c++)
        begin
            px            = row[c*PIX_W +: PIX_W];
            above_next[c] = (px > mean);
            diff          = above_next[c] ? (px - mean) : (mean - px);
            sq_next[c]    = SQ_W'(diff) * SQ_W'(diff);
        end
    end

    // Sum the registered squares of the row.
    always_comb
    begin
        sq_sum_next = '0;
        for (int c = 0; c < COLS; c++)
        begin
            sq_sum_next = sq_sum_next + SQ_ROW_W'(sq_reg[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < COLS; c++)
        begin
            sq_reg[c] <= sq_next[c];
        end
        above_reg  <= above_next;
        sq_sum_reg <= sq_sum_next;
        nibble_reg <= above_reg;
    end

    assign sq_sum = sq_sum_reg;
    assign nibble = nibble_reg;

endmodule

// ===== rtl/btc_sqrt_pipe.sv =====
module btc_sqrt_pipe
    import btc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [VAR_W-1:0] in_var,
    input  btc_side_t        in_side,
    output logic             out_valid,
    output logic [DEV_W-1:0] out_dev,
    output btc_side_t        out_side
);

    logic [SQRT_STAGES-1:0] valid_reg;
    sqrt_state_t            st_reg   [SQRT_STAGES];
    logic [VAR_W-1:0]       var_reg  [SQRT_STAGES];
    btc_side_t              side_reg [SQRT_STAGES];
    sqrt_state_t            st_next  [SQRT_STAGES];

    // Each stage resolves two root bits.
    for (genvar k = 0; k < SQRT_STAGES; k++)
    begin : g_stage
        sqrt_state_t      src_st;
        logic [VAR_W-1:0] src_var;

        if (k == 0)
        begin : g_first
            assign src_st  = '0;
            assign src_var = in_var;
        end
        else
        begin : g_rest
            assign src_st  = st_reg[k-1];
            assign src_var = var_reg[k-1];
        end

        always_comb
        begin
            sqrt_state_t s;
            s = src_st;
            for (int j = 0; j < STEPS_PER_STAGE; j++)
            begin
                s = sqrt_step(s, src_var[VAR_W-1-2*(STEPS_PER_STAGE*k+j) -: 2]);
            end
            st_next[k] = s;
        end
    end

    // Stage valids are control state; the data path needs no reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[SQRT_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < SQRT_STAGES; k++)
        begin
            st_reg[k] <= st_next[k];
        end
        var_reg[0]  <= in_var;
        side_reg[0] <= in_side;
        for (int k = 1; k < SQRT_STAGES; k++)
        begin
            var_reg[k]  <= var_reg[k-1];
            side_reg[k] <= side_reg[k-1];
        end
    end

    assign out_valid = valid_reg[SQRT_STAGES-1];
    assign out_dev   = st_reg[SQRT_STAGES-1].root[DEV_W-1:0];
    assign out_side  = side_reg[SQRT_STAGES-1];

endmodule

// ===== rtl/btc_block_encoder_4x4_top.sv =====
// Block truncation coding encoder for 4x4 blocks of 8-bit pixels. A block is
// transferred when start is high; busy is always low, so a new block may be
// given on every clock cycle. Each block passes nine register stages (two lane
// stages for the mean, three for the squared differences, four for the square
// root), and its result is marked by a one-cycle done pulse.
// The receiver cannot stall: the result is on block_mean, block_deviation and
// level_bitmap only during the cycle that done is high, and results leave in
// the order the blocks came in, one per cycle at most.
module btc_block_encoder_4x4_top
    import btc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [ROW_W-1:0]  row0_pixels,
    input  logic [ROW_W-1:0]  row1_pixels,
    input  logic [ROW_W-1:0]  row2_pixels,
    input  logic [ROW_W-1:0]  row3_pixels,
    output logic              done,
    output logic [MEAN_W-1:0] block_mean,
    output logic [DEV_W-1:0]  block_deviation,
    output logic [MAP_W-1:0]  level_bitmap
);

    localparam int FRONT_STAGES = 5;

    logic [ROW_W-1:0]     rows_in [ROWS];
    logic [ROW_W-1:0]     pix_s1_reg [ROWS];
    logic [ROW_W-1:0]     pix_s2_reg [ROWS];
    logic [SUM_ROW_W-1:0] row_sum [ROWS];
    logic [SQ_ROW_W-1:0]  sq_row_sum [ROWS];
    logic [COLS-1:0]      nibble [ROWS];
    logic [SUM_W-1:0]     total_next;
    logic [SQ_SUM_W-1:0]  sq_total_next;
    logic [MAP_W-1:0]     bitmap_next;
    logic [MEAN_W-1:0]    mean_s2_reg;
    logic [MEAN_W-1:0]    mean_s3_reg;
    logic [MEAN_W-1:0]    mean_s4_reg;
    logic [VAR_W-1:0]     var_s5_reg;
    btc_side_t            side_s5_reg;
    logic [FRONT_STAGES-1:0] valid_reg;
    btc_side_t            out_side;

    // The block never holds off a transfer.
    assign busy = 1'b0;

    assign rows_in[0] = row0_pixels;
    assign rows_in[1] = row1_pixels;
    assign rows_in[2] = row2_pixels;
    assign rows_in[3] = row3_pixels;

    // Row lanes: pixel sums, then squared differences and level bits.
    for (genvar r = 0; r < ROWS; r++)
    begin : g_lane
        btc_sum_lane u_sum_lane (
            .clk     (clk),
            .row     (rows_in[r]),
            .row_sum (row_sum[r])
        );

        btc_dev_lane u_dev_lane (
            .clk    (clk),
            .row    (pix_s2_reg[r]),
            .mean   (mean_s2_reg),
            .sq_sum (sq_row_sum[r]),
            .nibble (nibble[r])
        );
    end

    // Merge the row sums into the block sum.
    always_comb
    begin
        total_next = '0;
        for (int r = 0; r < ROWS; r++)
        begin
            total_next = total_next + SUM_W'(row_sum[r]);
        end
    end

    // Merge the row squared sums and the level bits.
    always_comb
    begin
        sq_total_next = '0;
        for (int r = 0; r < ROWS; r++)
        begin
            sq_total_next = sq_total_next + SQ_SUM_W'(sq_row_sum[r]);
            bitmap_next[r*COLS +: COLS] = nibble[r];
        end
    end

    // Transfer valids move down the front pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[FRONT_STAGES-2:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            pix_s1_reg[r] <= rows_in[r];
            pix_s2_reg[r] <= pix_s1_reg[r];
        end
        mean_s2_reg        <= total_next[SUM_W-1:MEAN_SHIFT];
        mean_s3_reg        <= mean_s2_reg;
        mean_s4_reg        <= mean_s3_reg;
        var_s5_reg         <= sq_total_next[SQ_SUM_W-1:MEAN_SHIFT];
        side_s5_reg.mean   <= mean_s4_reg;
        side_s5_reg.bitmap <= bitmap_next;
    end

    // Deviation from the mean squared difference.
    btc_sqrt_pipe u_sqrt_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_reg[FRONT_STAGES-1]),
        .in_var    (var_s5_reg),
        .in_side   (side_s5_reg),
        .out_valid (done),
        .out_dev   (block_deviation),
        .out_side  (out_side)
    );

    assign block_mean   = out_side.mean;
    assign level_bitmap = out_side.bitmap;

endmodule

// ===== tb/btc_block_encoder_4x4_top_test.sv =====
module btc_block_encoder_4x4_top_test;
    import btc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One block as four packed rows, row 0 in the low word.
    typedef logic [ROWS-1:0][ROW_W-1:0] pixel_block_t;

    // Code word that the encoder gives for one block.
    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic [DEV_W-1:0]  deviation;
        logic [MAP_W-1:0]  bitmap;
    } btc_code_t;

    // A block waiting to be sent, with the idle time that follows it.
    typedef struct {
        pixel_block_t pixels;
        int           gap_after;
        bit           drain_first;
    } block_job_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [ROW_W-1:0]  row0_pixels = '0;
    logic [ROW_W-1:0]  row1_pixels = '0;
    logic [ROW_W-1:0]  row2_pixels = '0;
    logic [ROW_W-1:0]  row3_pixels = '0;
    logic              done;
    logic [MEAN_W-1:0] block_mean;
    logic [DEV_W-1:0]  block_deviation;
    logic [MAP_W-1:0]  level_bitmap;

    block_job_t   pending_blocks[$];
    btc_code_t    expected_codes[$];
    pixel_block_t sent_block = '0;
    int           sent_gap = 0;
    int           idle_left = 0;
    bit           presenting = 1'b0;
    int           error_count = 0;

    btc_block_encoder_4x4_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .row0_pixels     (row0_pixels),
        .row1_pixels     (row1_pixels),
        .row2_pixels     (row2_pixels),
        .row3_pixels     (row3_pixels),
        .done            (done),
        .block_mean      (block_mean),
        .block_deviation (block_deviation),
        .level_bitmap    (level_bitmap)
    );

    // Free-running clock, 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Mean, deviation and bitmap of one block, computed pixel by pixel.
    function automatic btc_code_t predict_code(input pixel_block_t blk);
        int unsigned pix [ROWS*COLS];
        int unsigned total;
        int unsigned avg;
        int unsigned sq_sum;
        int unsigned mean_sq;
        int unsigned root;
        int          diff;
        btc_code_t   code;
        total  = 0;
        sq_sum = 0;
        code   = '0;
        for (int r = 0; r < ROWS; r++)
        begin
            for (int c = 0; c < COLS; c++)
            begin
                pix[r*COLS+c] = blk[r][c*PIX_W +: PIX_W];
                total += pix[r*COLS+c];
            end
        end
        avg = total / (ROWS * COLS);
        for (int k = 0; k < ROWS*COLS; k++)
        begin
            diff = int'(pix[k]) - int'(avg);
            sq_sum += diff * diff;
            // Only pixels strictly above the mean set their bit.
            if (pix[k] > avg)
                code.bitmap[k] = 1'b1;
        end
        mean_sq = sq_sum / (ROWS * COLS);
        // Largest root whose square does not exceed the mean square.
        root = 0;
        while ((root + 1) * (root + 1) <= mean_sq)
            root++;
        code.mean      = avg[MEAN_W-1:0];
        code.deviation = root[DEV_W-1:0];
        return code;
    endfunction

    task automatic add_block(input pixel_block_t blk, input int gap, input bit drain);
        block_job_t job;
        job.pixels      = blk;
        job.gap_after   = gap;
        job.drain_first = drain;
        pending_blocks.push_back(job);
    endtask

    // Driver: records each transfer, then idles or presents the next block.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_codes.push_back(predict_code(sent_block));
                idle_left  = sent_gap;
                presenting = 1'b0;
            end
            if (!presenting)
            begin
                if (idle_left > 0)
                    idle_left--;
                else if (pending_blocks.size() != 0 &&
                         (!pending_blocks[0].drain_first || expected_codes.size() == 0))
                begin
                    sent_block  = pending_blocks[0].pixels;
                    sent_gap    = pending_blocks[0].gap_after;
                    void'(pending_blocks.pop_front());
                    presenting  = 1'b1;
                    row0_pixels <= sent_block[0];
                    row1_pixels <= sent_block[1];
                    row2_pixels <= sent_block[2];
                    row3_pixels <= sent_block[3];
                end
            end
            start <= presenting;
        end
    end

    // Monitor: each strobed result is checked against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        btc_code_t want;
        if (rst_n && done)
        begin
            if (expected_codes.size() == 0)
            begin
                $error("unexpected result: mean %0d deviation %0d bitmap %h",
                       block_mean, block_deviation, level_bitmap);
                error_count++;
            end
            else
            begin
                want = expected_codes.pop_front();
                if (block_mean !== want.mean)
                begin
                    $error("block_mean: expected %0d, actual %0d", want.mean, block_mean);
                    error_count++;
                end
                if (block_deviation !== want.deviation)
                begin
                    $error("block_deviation: expected %0d, actual %0d",
                           want.deviation, block_deviation);
                    error_count++;
                end
                if (level_bitmap !== want.bitmap)
                begin
                    $error("level_bitmap: expected %h, actual %h", want.bitmap, level_bitmap);
                    error_count++;
                end
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        pixel_block_t blk;
        int           mode;
        int           gap;
        int           lo;
        int           hi;
        int           base;
        int           val;

        // Directed blocks: extremes, flat blocks, peak deviation, threshold ties.
        add_block({4{32'h0000_0000}}, 0, 1'b0);
        add_block({4{32'hFFFF_FFFF}}, 0, 1'b0);
        add_block({4{32'h8080_8080}}, 2, 1'b0);
        add_block({32'h00FF_00FF, 32'hFF00_FF00, 32'h00FF_00FF, 32'hFF00_FF00}, 0, 1'b0);
        add_block({32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 0, 1'b0);
        add_block({32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_00FF}, 0, 1'b0);
        add_block({32'hFF00_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1, 1'b0);
        add_block({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FF00}, 0, 1'b0);
        add_block({32'h0F0E_0D0C, 32'h0B0A_0908, 32'h0706_0504, 32'h0302_0100}, 0, 1'b0);
        add_block({32'hFFEE_DDCC, 32'hBBAA_9988, 32'h7766_5544, 32'h3322_1100}, 0, 1'b0);
        add_block({4{32'hAAAA_AAAA}}, 0, 1'b0);
        add_block({4{32'h5555_5555}}, 3, 1'b0);
        add_block({32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000}, 0, 1'b0);
        // Pixels equal to the mean stay clear; only the one above it is set.
        add_block({32'h0A0A_0A0A, 32'h0A0A_0A0A, 32'h0A0B_0A0A, 32'h0A0A_0A0A}, 0, 1'b0);
        add_block({32'h190A_0A0A, 32'h0A0A_0A0A, 32'h0A0A_0A0A, 32'h0A0A_0A0A}, 0, 1'b0);
        // Mean rounds down to zero, so every nonzero pixel is above it.
        add_block({32'h0101_0101, 32'h0101_0101, 32'h0101_0101, 32'h0101_0100}, 0, 1'b0);
        add_block({32'h7F7F_7F7F, 32'h8080_8080, 32'h7F7F_7F7F, 32'h8080_8080}, 0, 1'b0);

        // Random blocks of several shapes; the last stretch runs with no idling.
        for (int i = 0; i < 450; i++)
        begin
            mode = $urandom_range(0, 4);
            lo   = $urandom_range(0, 255);
            hi   = $urandom_range(0, 255);
            base = $urandom_range(0, 255);
            blk  = '0;
            for (int k = 0; k < ROWS*COLS; k++)
            begin
                case (mode)
                    0, 1: val = $urandom_range(0, 255);
                    2: val = $urandom_range(0, 1) ? hi : lo;
                    3:
                    begin
                        val = base + $urandom_range(0, 6) - 3;
                        if (val < 0)
                            val = 0;
                        if (val > 255)
                            val = 255;
                    end
                    default: val = base;
                endcase
                blk[k/COLS][(k%COLS)*PIX_W +: PIX_W] = val[PIX_W-1:0];
            end
            if (mode == 0)
            begin
                for (int r = 0; r < ROWS; r++)
                    blk[r] = $urandom;
            end
            gap = 0;
            if (i < 380 && !(i >= 120 && i < 180) && $urandom_range(0, 3) == 0)
                gap = $urandom_range(1, 18);
            add_block(blk, gap, (i == 0 || i == 250));
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_blocks.size() != 0 || start)
            @(posedge clk);
        while (expected_codes.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (error_count == 0 && expected_codes.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog for a hung run.
    initial
    begin
        #2ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/btc_pkg.sv
rtl/btc_sum_lane.sv
rtl/btc_dev_lane.sv
rtl/btc_sqrt_pipe.sv
rtl/btc_block_encoder_4x4_top.sv
tb/btc_block_encoder_4x4_top_test.sv
